// ----- src/rth_pkg.sv -----
// rth_pkg: shared types and constants for the RGB to HSV pixel converter.
// No dependencies; imported by every rth_* module and the top level.

package rth_pkg;

    localparam int PIX_W      = 8;
    localparam int GAIN_W     = 10;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd256;

    localparam int FRAC_W     = 16;
    localparam int NUM_W      = 17;
    localparam int DIV_W      = NUM_W + FRAC_W;
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = DIV_W / DIV_STEP;

    localparam int PIPE_STAGES = DIV_STAGES + 3;
    localparam int PIPE_LAST   = PIPE_STAGES - 1;

    localparam int HUE_Q_W    = 25;
    localparam int SAT_Q_W    = 24;
    localparam int T_W        = 17;

    localparam logic [8:0] DEG_RED   = 9'd360;
    localparam logic [8:0] DEG_GREEN = 9'd120;
    localparam logic [8:0] DEG_BLUE  = 9'd240;
    localparam logic [8:0] DEG_FULL  = 9'd360;

    // floor(n/45) = (n * 11651) >> 19 for n below 2^14
    localparam logic [13:0] RECIP_45 = 14'd11651;
    localparam int          RECIP_SH = 19;

    typedef struct packed {
        logic [PIX_W-1:0] den;
        logic [PIX_W-1:0] rem;
        logic [DIV_W-1:0] acc;
    } div_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             red_sec;
        logic             grey;
        logic             black;
    } side_t;

endpackage

// ----- src/rth_front.sv -----
// rth_front: first stage; max/min, hue sector and both division operands.
// Depends on rth_pkg.

module rth_front
    import rth_pkg::*;
(
    input  logic             clk,
    input  logic             ld,
    input  logic [PIX_W-1:0] red,
    input  logic [PIX_W-1:0] green,
    input  logic [PIX_W-1:0] blue,
    output div_t             hue_div,
    output div_t             sat_div,
    output side_t            side
);

    div_t  hue_div_reg;
    div_t  hue_div_next;
    div_t  sat_div_reg;
    div_t  sat_div_next;
    side_t side_reg;
    side_t side_next;

    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] span;
    logic [PIX_W-1:0] pos;
    logic [PIX_W-1:0] neg;
    logic [8:0]       base_k;
    logic             red_sec;
    logic [17:0]      num_wide;
    logic [15:0]      sat_num;

    always_comb
    begin
        red_sec = 1'b0;
        priority if (red >= green && red >= blue)
        begin
            hi      = red;
            red_sec = 1'b1;
            base_k  = DEG_RED;
            pos     = green;
            neg     = blue;
        end
        else if (green >= blue)
        begin
            hi     = green;
            base_k = DEG_GREEN;
            pos    = blue;
            neg    = red;
        end
        else
        begin
            hi     = blue;
            base_k = DEG_BLUE;
            pos    = red;
            neg    = green;
        end

        lo = red;
        if (green < lo)
        begin
            lo = green;
        end
        if (blue < lo)
        begin
            lo = blue;
        end

        span     = hi - lo;
        num_wide = 18'(base_k) * 18'(span) + 18'(pos) * 18'd60 - 18'(neg) * 18'd60;
        sat_num  = {span, 8'd0} - {8'd0, span};

        hue_div_next.den = span;
        hue_div_next.rem = '0;
        hue_div_next.acc = {num_wide[NUM_W-1:0], {FRAC_W{1'b0}}};

        sat_div_next.den = hi;
        sat_div_next.rem = '0;
        sat_div_next.acc = {1'b0, sat_num, {FRAC_W{1'b0}}};

        side_next.value   = hi;
        side_next.red_sec = red_sec;
        side_next.grey    = (span == '0);
        side_next.black   = (hi == '0);
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            hue_div_reg <= hue_div_next;
            sat_div_reg <= sat_div_next;
            side_reg    <= side_next;
        end
    end

    assign hue_div = hue_div_reg;
    assign sat_div = sat_div_reg;
    assign side    = side_reg;

endmodule

// ----- src/rth_div_step.sv -----
// rth_div_step: one divider stage, DIV_STEP (3) restoring quotient bits for the
// hue and saturation quotients side by side. Depends on rth_pkg.

module rth_div_step
    import rth_pkg::*;
(
    input  logic  clk,
    input  logic  ld,
    input  div_t  hue_in,
    input  div_t  sat_in,
    input  side_t side_in,
    output div_t  hue_out,
    output div_t  sat_out,
    output side_t side_out
);

    div_t  hue_reg;
    div_t  hue_next;
    div_t  sat_reg;
    div_t  sat_next;
    side_t side_reg;

    function automatic div_t div_bit(input div_t d);
        logic [PIX_W:0] trial;
        div_t           r;
        trial = {d.rem, d.acc[DIV_W-1]};
        r     = d;
        r.acc = {d.acc[DIV_W-2:0], 1'b0};
        if (trial >= {1'b0, d.den})
        begin
            r.rem    = PIX_W'(trial - {1'b0, d.den});
            r.acc[0] = 1'b1;
        end
        else
        begin
            r.rem = trial[PIX_W-1:0];
        end
        return r;
    endfunction

    always_comb
    begin
        hue_next = hue_in;
        sat_next = sat_in;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            hue_next = div_bit(hue_next);
            sat_next = div_bit(sat_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            hue_reg  <= hue_next;
            sat_reg  <= sat_next;
            side_reg <= side_in;
        end
    end

    assign hue_out  = hue_reg;
    assign sat_out  = sat_reg;
    assign side_out = side_reg;

endmodule

// ----- src/rth_back.sv -----
// rth_back: last two stages; hue scaling to 255/360 and saturation gain
// with clamp, ending in the output register. Depends on rth_pkg.

module rth_back
    import rth_pkg::*;
(
    input  logic              clk,
    input  logic              ld1,
    input  logic              ld2,
    input  logic [GAIN_W-1:0] gain,
    input  div_t              hue_q,
    input  div_t              sat_q,
    input  side_t             side_in,
    output logic [PIX_W-1:0]  hue,
    output logic [PIX_W-1:0]  saturation,
    output logic [PIX_W-1:0]  value
);

    logic [HUE_Q_W-1:0] hq;
    logic [8:0]         deg;
    logic [32:0]        hprod;
    logic [33:0]        sprod;

    logic [T_W-1:0]     t_reg;
    logic [T_W-1:0]     t_next;
    logic [9:0]         satp_reg;
    logic [9:0]         satp_next;
    logic               grey_reg;
    logic [PIX_W-1:0]   value1_reg;

    logic [27:0]        hdiv;

    logic [PIX_W-1:0]   hue_reg;
    logic [PIX_W-1:0]   hue_next;
    logic [PIX_W-1:0]   sat_reg;
    logic [PIX_W-1:0]   sat_next;
    logic [PIX_W-1:0]   value_reg;

    // red sector wraps whole degrees mod 360 before scaling
    always_comb
    begin
        hq    = hue_q.acc[HUE_Q_W-1:0];
        deg   = hq[HUE_Q_W-1:FRAC_W];
        if (deg >= DEG_FULL)
        begin
            deg = deg - DEG_FULL;
        end
        hprod = 33'(hq) * 33'd255;
        if (side_in.red_sec)
        begin
            t_next = T_W'(deg) * T_W'(255);
        end
        else
        begin
            t_next = hprod[32:FRAC_W];
        end
        sprod     = 34'(sat_q.acc[SAT_Q_W-1:0]) * 34'(gain);
        satp_next = side_in.black ? 10'd0 : sprod[33:24];
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            t_reg      <= t_next;
            satp_reg   <= satp_next;
            grey_reg   <= side_in.grey;
            value1_reg <= side_in.value;
        end
    end

    // t/360 taken as (t/8)/45
    always_comb
    begin
        hdiv     = 28'(t_reg[T_W-1:3]) * 28'(RECIP_45);
        hue_next = grey_reg ? '0 : hdiv[RECIP_SH+PIX_W-1:RECIP_SH];
        sat_next = (satp_reg > 10'd255) ? 8'd255 : satp_reg[PIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            value_reg <= value1_reg;
        end
    end

    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign value      = value_reg;

endmodule

// ----- src/rgb_to_hsv_pixel.sv -----
// rgb_to_hsv_pixel: top level; handshake pipeline control, gain register.
// Depends on rth_pkg, rth_front, rth_div_step and rth_back.
//
// Usage:
//   Slave stream s_* takes one pixel request per beat: s_tdata holds red,
//   green and blue. Master stream m_* returns hue, saturation and value.
//   sat_gain_we/sat_gain_data write the Q2.8 saturation gain (reset 1.0);
//   write it only while the pipeline is empty.
//   Stages: front stage, 11 divider stages of 3 quotient bits each, two
//   output stages.
//   Throughput: one request per cycle when not stalled; each stage holds
//   one request and advances whenever the stage ahead is empty or moving.
//   Stall: with m_tready low the output holds; requests behind it close up
//   any gaps, and s_tready falls only once all 14 stages are occupied.
//   Reset: all stages empty, gain back to 256.

module rgb_to_hsv_pixel
    import rth_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,       // red, green, blue
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,       // hue, saturation, value
    input  logic              sat_gain_we,
    input  logic [GAIN_W-1:0] sat_gain_data
);

    logic [GAIN_W-1:0]      sat_gain_reg;
    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] rdy;

    div_t  hdiv [0:DIV_STAGES];
    div_t  sdiv [0:DIV_STAGES];
    side_t side [0:DIV_STAGES];

    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] saturation;
    logic [PIX_W-1:0] value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_gain_reg <= GAIN_RESET;
        end
        else if (sat_gain_we)
        begin
            sat_gain_reg <= sat_gain_data;
        end
    end

    always_comb
    begin
        rdy[PIPE_LAST] = !vld_reg[PIPE_LAST] || m_tready;
        for (int k = PIPE_LAST - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < PIPE_STAGES; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    rth_front u_front (
        .clk     (clk),
        .ld      (rdy[0]),
        .red     (s_tdata[7:0]),
        .green   (s_tdata[15:8]),
        .blue    (s_tdata[23:16]),
        .hue_div (hdiv[0]),
        .sat_div (sdiv[0]),
        .side    (side[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        rth_div_step u_step (
            .clk      (clk),
            .ld       (rdy[g+1]),
            .hue_in   (hdiv[g]),
            .sat_in   (sdiv[g]),
            .side_in  (side[g]),
            .hue_out  (hdiv[g+1]),
            .sat_out  (sdiv[g+1]),
            .side_out (side[g+1])
        );
    end

    rth_back u_back (
        .clk        (clk),
        .ld1        (rdy[DIV_STAGES+1]),
        .ld2        (rdy[DIV_STAGES+2]),
        .gain       (sat_gain_reg),
        .hue_q      (hdiv[DIV_STAGES]),
        .sat_q      (sdiv[DIV_STAGES]),
        .side_in    (side[DIV_STAGES]),
        .hue        (hue),
        .saturation (saturation),
        .value      (value)
    );

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[PIPE_LAST];
    assign m_tdata  = {value, saturation, hue};

    a_black_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[23:16] == 8'd0 |-> m_tdata[15:0] == 16'd0)
        else $error("black pixel with non-zero hue or saturation");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:0] != 8'hFF)
        else $error("hue out of range");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> &vld_reg)
        else $error("input stalled with an empty stage");

endmodule
